// ----- rtl/dpb_pkg.sv -----
`timescale 1ns / 1ps

package dpb_pkg;

  // Default sizes of the coordinate and depth formats.
  localparam int unsigned CoordBitsDefault     = 12;
  localparam int unsigned DepthFracBitsDefault = 6;

  // Fixed port widths.
  localparam int unsigned PixW     = 12;
  localparam int unsigned DepthInW = 16;
  localparam int unsigned PointW   = 32;
  localparam int unsigned ClampW   = 14;

  // Register file layout.
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 60;
  localparam int unsigned CoefW      = 20;
  localparam int unsigned InvFocalW  = 24;
  localparam int unsigned SizeW      = 24;
  localparam int unsigned RatioW     = 40;
  localparam int unsigned RatioFldW  = 20;

  // Fixed-point scaling.
  localparam int unsigned RotFracBits = 18;
  localparam int unsigned FocalShift  = 25;
  localparam int unsigned ColourShift = 16;

  // Depth clamp rule, in whole depth units.
  localparam int unsigned DepthLimit    = 150;
  localparam int unsigned DepthReplace  = 160;
  localparam int unsigned DepthReplaceW = $clog2(DepthReplace + 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegRot0        = 3'd0,
    RegRot1        = 3'd1,
    RegRot2        = 3'd2,
    RegTrans       = 3'd3,
    RegInvFocal    = 3'd4,
    RegImgSize     = 3'd5,
    RegColourRatio = 3'd6
  } reg_idx_e;

  localparam logic [CfgDataW-1:0] RotRow0Reset  = 60'h000_0000_0004_0000;
  localparam logic [CfgDataW-1:0] RotRow1Reset  = 60'h000_0040_0000_0000;
  localparam logic [CfgDataW-1:0] RotRow2Reset  = 60'h400_0000_0000_0000;
  localparam logic [CfgDataW-1:0] TransReset    = '0;
  localparam logic [InvFocalW-1:0] InvFocalReset = 24'd65536;
  localparam logic [SizeW-1:0]     ImgSizeReset  = 24'd1966720;
  localparam logic [RatioW-1:0]    ColourRatioReset = 40'd68719542272;

  typedef struct packed {
    logic [2:0][CfgDataW-1:0] rot;
    logic [CfgDataW-1:0]      trans;
    logic [InvFocalW-1:0]     inv_focal;
    logic [SizeW-1:0]         img_size;
    logic [RatioW-1:0]        colour_ratio;
  } cfg_t;

  // Width of the clamped depth: it holds the input magnitude and the
  // replacement depth.
  function automatic int unsigned depth_width(input int unsigned frac_bits);
    return (frac_bits + DepthReplaceW > DepthInW - 1) ? frac_bits + DepthReplaceW
                                                      : DepthInW - 1;
  endfunction

  // Width of a back-projected camera-space coordinate.
  function automatic int unsigned vec_width(input int unsigned coord_bits,
                                            input int unsigned frac_bits);
    return coord_bits + depth_width(frac_bits) + 2;
  endfunction

endpackage

// ----- rtl/dpb_cfg_regs.sv -----
`timescale 1ns / 1ps

module dpb_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [dpb_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dpb_pkg::CfgDataW-1:0]   cfg_data_i,
  output dpb_pkg::cfg_t                  cfg_o
);

  dpb_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot[0]       <= dpb_pkg::RotRow0Reset;
      cfg_q.rot[1]       <= dpb_pkg::RotRow1Reset;
      cfg_q.rot[2]       <= dpb_pkg::RotRow2Reset;
      cfg_q.trans        <= dpb_pkg::TransReset;
      cfg_q.inv_focal    <= dpb_pkg::InvFocalReset;
      cfg_q.img_size     <= dpb_pkg::ImgSizeReset;
      cfg_q.colour_ratio <= dpb_pkg::ColourRatioReset;
    end else if (cfg_valid_i) begin
      case (dpb_pkg::reg_idx_e'(cfg_index_i))
        dpb_pkg::RegRot0:        cfg_q.rot[0] <= cfg_data_i;
        dpb_pkg::RegRot1:        cfg_q.rot[1] <= cfg_data_i;
        dpb_pkg::RegRot2:        cfg_q.rot[2] <= cfg_data_i;
        dpb_pkg::RegTrans:       cfg_q.trans  <= cfg_data_i;
        dpb_pkg::RegInvFocal:    cfg_q.inv_focal <= cfg_data_i[dpb_pkg::InvFocalW-1:0];
        dpb_pkg::RegImgSize:     cfg_q.img_size  <= cfg_data_i[dpb_pkg::SizeW-1:0];
        dpb_pkg::RegColourRatio: cfg_q.colour_ratio <= cfg_data_i[dpb_pkg::RatioW-1:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/dpb_project.sv -----
`timescale 1ns / 1ps

module dpb_project #(
  parameter int unsigned CoordBits     = dpb_pkg::CoordBitsDefault,
  parameter int unsigned DepthFracBits = dpb_pkg::DepthFracBitsDefault,
  localparam int unsigned DepthW = dpb_pkg::depth_width(DepthFracBits),
  localparam int unsigned VecW   = dpb_pkg::vec_width(CoordBits, DepthFracBits)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dpb_pkg::cfg_t                       cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dpb_pkg::PixW-1:0]            pixel_row_i,
  input  logic [dpb_pkg::PixW-1:0]            pixel_col_i,
  input  logic signed [dpb_pkg::DepthInW-1:0] depth_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [VecW-1:0]              vec_x_o,
  output logic signed [VecW-1:0]              vec_y_o,
  output logic [DepthW-1:0]                   depth_o,
  output logic [CoordBits-1:0]                colour_row_o,
  output logic [CoordBits-1:0]                colour_col_o
);

  localparam int unsigned HalfW    = CoordBits + 2;
  localparam int unsigned MulW     = HalfW + DepthW + 1;
  localparam int unsigned ProjW    = MulW + dpb_pkg::InvFocalW + 1;
  localparam int unsigned ColW     = CoordBits + dpb_pkg::RatioFldW;
  localparam int unsigned ColRndW  = ColW + 1;
  localparam int unsigned SizeExtW = 2 * CoordBits;
  localparam int unsigned DepthLimitUnits = dpb_pkg::DepthLimit << DepthFracBits;
  localparam int unsigned DepthRepUnits   = dpb_pkg::DepthReplace << DepthFracBits;
  localparam int unsigned FocalHalf  = 1 << (dpb_pkg::FocalShift - 1);
  localparam int unsigned ColourHalf = 1 << (dpb_pkg::ColourShift - 1);

  // Stage handshake.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign out_valid_o = v4_q;

  // Stage 1: clamp the depth and centre the pixel coordinates.
  logic [SizeExtW-1:0]          size_ext;
  logic [CoordBits-1:0]         cols, rows;
  logic [CoordBits-1:0]         row_d, col_d;
  logic                         depth_neg, depth_over;
  logic [DepthW-1:0]            depth_d;
  logic signed [HalfW-1:0]      hx_d, hy_d;

  assign size_ext   = SizeExtW'(cfg_i.img_size);
  assign cols       = size_ext[CoordBits-1:0];
  assign rows       = size_ext[SizeExtW-1:CoordBits];
  assign row_d      = CoordBits'(pixel_row_i);
  assign col_d      = CoordBits'(pixel_col_i);
  assign depth_neg  = depth_value_i[dpb_pkg::DepthInW-1];
  assign depth_over = 32'(depth_value_i[dpb_pkg::DepthInW-2:0]) >= DepthLimitUnits;
  assign depth_d    = (depth_neg || depth_over) ? DepthW'(DepthRepUnits)
                                                : DepthW'(depth_value_i[dpb_pkg::DepthInW-2:0]);
  assign hx_d = $signed({1'b0, col_d, 1'b0}) - $signed({2'b00, cols});
  assign hy_d = $signed({1'b0, row_d, 1'b0}) - $signed({2'b00, rows});

  logic [CoordBits-1:0]    row1_q, col1_q;
  logic [DepthW-1:0]       d1_q;
  logic signed [HalfW-1:0] hx1_q, hy1_q;

  // Stage 2: scale by depth; colour coordinate products.
  logic signed [MulW-1:0] mx_d, my_d, mx2_q, my2_q;
  logic [ColW-1:0]        crow_d, ccol_d, crow2_q, ccol2_q;
  logic [DepthW-1:0]      d2_q;

  assign mx_d   = hx1_q * $signed({1'b0, d1_q});
  assign my_d   = hy1_q * $signed({1'b0, d1_q});
  assign crow_d = row1_q * cfg_i.colour_ratio[dpb_pkg::RatioW-1:dpb_pkg::RatioFldW];
  assign ccol_d = col1_q * cfg_i.colour_ratio[dpb_pkg::RatioFldW-1:0];

  // Stage 3: scale by the focal reciprocal; round and saturate colour.
  logic signed [ProjW-1:0] px_d, py_d, px3_q, py3_q;
  logic [DepthW-1:0]       d3_q;
  logic [ColRndW-1:0]      crow_sum, ccol_sum;
  logic [ColRndW-dpb_pkg::ColourShift-1:0] crow_sh, ccol_sh;
  logic [CoordBits-1:0]    crow_d3, ccol_d3, crow3_q, ccol3_q;

  assign px_d = mx2_q * $signed({1'b0, cfg_i.inv_focal});
  assign py_d = my2_q * $signed({1'b0, cfg_i.inv_focal});
  assign crow_sum = ColRndW'(crow2_q) + ColRndW'(ColourHalf);
  assign ccol_sum = ColRndW'(ccol2_q) + ColRndW'(ColourHalf);
  assign crow_sh  = crow_sum[ColRndW-1:dpb_pkg::ColourShift];
  assign ccol_sh  = ccol_sum[ColRndW-1:dpb_pkg::ColourShift];
  assign crow_d3  = (|crow_sh[ColRndW-dpb_pkg::ColourShift-1:CoordBits]) ? '1
                                                                       : crow_sh[CoordBits-1:0];
  assign ccol_d3  = (|ccol_sh[ColRndW-dpb_pkg::ColourShift-1:CoordBits]) ? '1
                                                                       : ccol_sh[CoordBits-1:0];

  // Stage 4: divide by 2^25, rounding half away from zero.
  logic signed [ProjW:0]  px_rnd, py_rnd;
  logic signed [VecW-1:0] vx_d, vy_d, vx4_q, vy4_q;
  logic [DepthW-1:0]      d4_q;
  logic [CoordBits-1:0]   crow4_q, ccol4_q;

  assign px_rnd = {px3_q[ProjW-1], px3_q} + (ProjW+1)'(FocalHalf)
                - (ProjW+1)'(px3_q[ProjW-1]);
  assign py_rnd = {py3_q[ProjW-1], py3_q} + (ProjW+1)'(FocalHalf)
                - (ProjW+1)'(py3_q[ProjW-1]);
  assign vx_d = VecW'(px_rnd >>> dpb_pkg::FocalShift);
  assign vy_d = VecW'(py_rnd >>> dpb_pkg::FocalShift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      // A pixel of zero depth is taken but enters no stage.
      if (rdy1) v1_q <= in_valid_i && (depth_d != '0);
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      row1_q <= row_d;
      col1_q <= col_d;
      d1_q   <= depth_d;
      hx1_q  <= hx_d;
      hy1_q  <= hy_d;
    end
    if (rdy2) begin
      mx2_q   <= mx_d;
      my2_q   <= my_d;
      crow2_q <= crow_d;
      ccol2_q <= ccol_d;
      d2_q    <= d1_q;
    end
    if (rdy3) begin
      px3_q   <= px_d;
      py3_q   <= py_d;
      crow3_q <= crow_d3;
      ccol3_q <= ccol_d3;
      d3_q    <= d2_q;
    end
    if (rdy4) begin
      vx4_q   <= vx_d;
      vy4_q   <= vy_d;
      crow4_q <= crow3_q;
      ccol4_q <= ccol3_q;
      d4_q    <= d3_q;
    end
  end

  assign vec_x_o      = vx4_q;
  assign vec_y_o      = vy4_q;
  assign depth_o      = d4_q;
  assign colour_row_o = crow4_q;
  assign colour_col_o = ccol4_q;

endmodule

// ----- rtl/dpb_transform.sv -----
`timescale 1ns / 1ps

module dpb_transform #(
  parameter int unsigned CoordBits     = dpb_pkg::CoordBitsDefault,
  parameter int unsigned DepthFracBits = dpb_pkg::DepthFracBitsDefault,
  localparam int unsigned DepthW = dpb_pkg::depth_width(DepthFracBits),
  localparam int unsigned VecW   = dpb_pkg::vec_width(CoordBits, DepthFracBits)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dpb_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [VecW-1:0]            vec_x_i,
  input  logic signed [VecW-1:0]            vec_y_i,
  input  logic [DepthW-1:0]                 depth_i,
  input  logic [CoordBits-1:0]              colour_row_i,
  input  logic [CoordBits-1:0]              colour_col_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [dpb_pkg::PointW-1:0] point_x_o,
  output logic signed [dpb_pkg::PointW-1:0] point_y_o,
  output logic signed [dpb_pkg::PointW-1:0] point_z_o,
  output logic [dpb_pkg::ClampW-1:0]        clamped_depth_o,
  output logic [CoordBits-1:0]              colour_row_o,
  output logic [CoordBits-1:0]              colour_col_o
);

  localparam int unsigned ProdW = dpb_pkg::CoefW + VecW;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned RndW  = SumW + 1 - dpb_pkg::RotFracBits;
  localparam int unsigned AddW  = ((RndW > dpb_pkg::CoefW) ? RndW : dpb_pkg::CoefW) + 1;
  localparam int unsigned ExtW  = (AddW > dpb_pkg::PointW + 1) ? AddW : dpb_pkg::PointW + 1;
  localparam int unsigned RotHalf  = 1 << (dpb_pkg::RotFracBits - 1);
  localparam int unsigned ClampMax = (1 << dpb_pkg::ClampW) - 1;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4        = !v4_q || out_ready_i;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign in_ready_o  = rdy1;
  assign out_valid_o = v4_q;

  // Stage 1: the nine rotation products.
  logic signed [VecW-1:0]  vec [3];
  logic signed [ProdW-1:0] prod_d [3][3];
  logic signed [ProdW-1:0] prod_q [3][3];

  assign vec[0] = vec_x_i;
  assign vec[1] = vec_y_i;
  assign vec[2] = $signed(VecW'(depth_i));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = $signed(cfg_i.rot[i][dpb_pkg::CoefW*j +: dpb_pkg::CoefW]) * vec[j];
      end
    end
  end

  // Stage 2: row sums. Stage 3: rounding shift. Stage 4: translate, saturate.
  logic signed [SumW-1:0]   sum_d [3];
  logic signed [SumW-1:0]   sum_q [3];
  logic signed [SumW:0]     rnd_tmp [3];
  logic signed [RndW-1:0]   rnd_d [3];
  logic signed [RndW-1:0]   rnd_q [3];
  logic signed [AddW-1:0]   add_v [3];
  logic signed [ExtW-1:0]   ext_v [3];
  logic signed [dpb_pkg::PointW-1:0] point_d [3];
  logic signed [dpb_pkg::PointW-1:0] point_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i]   = SumW'(prod_q[i][0]) + SumW'(prod_q[i][1]) + SumW'(prod_q[i][2]);
      rnd_tmp[i] = {sum_q[i][SumW-1], sum_q[i]} + (SumW+1)'(RotHalf)
                 - (SumW+1)'(sum_q[i][SumW-1]);
      rnd_d[i]   = RndW'(rnd_tmp[i] >>> dpb_pkg::RotFracBits);
      add_v[i]   = AddW'(rnd_q[i])
                 + AddW'($signed(cfg_i.trans[dpb_pkg::CoefW*i +: dpb_pkg::CoefW]));
      ext_v[i]   = ExtW'(add_v[i]);
      if (!((&ext_v[i][ExtW-1:dpb_pkg::PointW-1]) || !(|ext_v[i][ExtW-1:dpb_pkg::PointW-1]))) begin
        point_d[i] = ext_v[i][ExtW-1] ? {1'b1, {(dpb_pkg::PointW-1){1'b0}}}
                                      : {1'b0, {(dpb_pkg::PointW-1){1'b1}}};
      end else begin
        point_d[i] = ext_v[i][dpb_pkg::PointW-1:0];
      end
    end
  end

  logic [DepthW-1:0]         d1_q, d2_q, d3_q;
  logic [CoordBits-1:0]      crow1_q, crow2_q, crow3_q, crow4_q;
  logic [CoordBits-1:0]      ccol1_q, ccol2_q, ccol3_q, ccol4_q;
  logic [dpb_pkg::ClampW-1:0] clamp_d, clamp_q;

  assign clamp_d = (32'(d3_q) > ClampMax) ? dpb_pkg::ClampW'(ClampMax)
                                          : dpb_pkg::ClampW'(d3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      prod_q  <= prod_d;
      d1_q    <= depth_i;
      crow1_q <= colour_row_i;
      ccol1_q <= colour_col_i;
    end
    if (rdy2) begin
      sum_q   <= sum_d;
      d2_q    <= d1_q;
      crow2_q <= crow1_q;
      ccol2_q <= ccol1_q;
    end
    if (rdy3) begin
      rnd_q   <= rnd_d;
      d3_q    <= d2_q;
      crow3_q <= crow2_q;
      ccol3_q <= ccol2_q;
    end
    if (rdy4) begin
      point_q <= point_d;
      clamp_q <= clamp_d;
      crow4_q <= crow3_q;
      ccol4_q <= ccol3_q;
    end
  end

  assign point_x_o       = point_q[0];
  assign point_y_o       = point_q[1];
  assign point_z_o       = point_q[2];
  assign clamped_depth_o = clamp_q;
  assign colour_row_o    = crow4_q;
  assign colour_col_o    = ccol4_q;

endmodule

// ----- rtl/depth_pixel_backprojection_top.sv -----
`timescale 1ns / 1ps

// Depth pixel back-projection with a rigid transform.
// Each request on the input channel (in_valid_i / in_ready_o) carries one depth
// pixel: row, column and a signed depth in fractional depth units. The block
// clamps the depth, back-projects the pixel through a pinhole model centred on
// half the depth image size, rotates and translates the point, and returns the
// point, the clamped depth and the rounded colour-image coordinates as one
// request on the output channel (out_valid_o / out_ready_i).
// A pixel of zero depth is accepted and produces no output request.
// The pipeline has eight register stages, four in the projection and four in the
// transform; one pixel is accepted every cycle while the receiver takes results.
// Every stage has its own valid bit and may fill while later stages are held,
// so when the receiver stalls the block keeps accepting pixels until all eight
// stages are full; nothing is dropped or repeated.
// Registers are written through the configuration channel (cfg_valid_i, cfg_ready_o,
// which is always high); the user must write them only while the pipeline is empty,
// as the block does not enforce it. Reset clears every valid bit and loads identity
// rotation, zero translation, a 640x480 depth image and unit colour ratios.

module depth_pixel_backprojection_top #(
  parameter int unsigned CoordBits     = dpb_pkg::CoordBitsDefault,
  parameter int unsigned DepthFracBits = dpb_pkg::DepthFracBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dpb_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [dpb_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dpb_pkg::PixW-1:0]            pixel_row_i,
  input  logic [dpb_pkg::PixW-1:0]            pixel_col_i,
  input  logic signed [dpb_pkg::DepthInW-1:0] depth_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dpb_pkg::PointW-1:0]   point_x_o,
  output logic signed [dpb_pkg::PointW-1:0]   point_y_o,
  output logic signed [dpb_pkg::PointW-1:0]   point_z_o,
  output logic [dpb_pkg::ClampW-1:0]          clamped_depth_o,
  output logic [dpb_pkg::PixW-1:0]            colour_row_o,
  output logic [dpb_pkg::PixW-1:0]            colour_col_o
);

  localparam int unsigned DepthW = dpb_pkg::depth_width(DepthFracBits);
  localparam int unsigned VecW   = dpb_pkg::vec_width(CoordBits, DepthFracBits);

  dpb_pkg::cfg_t cfg;

  // The register file takes a write in every cycle.
  assign cfg_ready_o = 1'b1;

  dpb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Camera-space point handed from the projection stages to the transform.
  logic                   mid_valid, mid_ready;
  logic signed [VecW-1:0] mid_vx, mid_vy;
  logic [DepthW-1:0]      mid_depth;
  logic [CoordBits-1:0]   mid_crow, mid_ccol;
  logic [CoordBits-1:0]   out_crow, out_ccol;

  dpb_project #(
    .CoordBits     (CoordBits),
    .DepthFracBits (DepthFracBits)
  ) u_project (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .depth_value_i (depth_value_i),
    .out_valid_o   (mid_valid),
    .out_ready_i   (mid_ready),
    .vec_x_o       (mid_vx),
    .vec_y_o       (mid_vy),
    .depth_o       (mid_depth),
    .colour_row_o  (mid_crow),
    .colour_col_o  (mid_ccol)
  );

  dpb_transform #(
    .CoordBits     (CoordBits),
    .DepthFracBits (DepthFracBits)
  ) u_transform (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (mid_valid),
    .in_ready_o      (mid_ready),
    .vec_x_i         (mid_vx),
    .vec_y_i         (mid_vy),
    .depth_i         (mid_depth),
    .colour_row_i    (mid_crow),
    .colour_col_i    (mid_ccol),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .point_x_o       (point_x_o),
    .point_y_o       (point_y_o),
    .point_z_o       (point_z_o),
    .clamped_depth_o (clamped_depth_o),
    .colour_row_o    (out_crow),
    .colour_col_o    (out_ccol)
  );

  assign colour_row_o = dpb_pkg::PixW'(out_crow);
  assign colour_col_o = dpb_pkg::PixW'(out_ccol);

  // Zero-depth pixels never reach the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> clamped_depth_o != '0)
    else $error("output request with zero clamped depth");

  // The input side only stalls when every stage is full behind a held output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the pipeline has room");

  // A point held between the two halves keeps its value until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_valid && !mid_ready) |=>
      (mid_valid && $stable(mid_vx) && $stable(mid_vy) && $stable(mid_depth)))
    else $error("held point changed between projection and transform");

endmodule
